// ----- hdl/bsfj_pkg.sv -----
package bsfj_pkg;

    localparam int W = 64;
    localparam logic signed [W-1:0] WMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    localparam int REG_W = 31;
    localparam logic [REG_W-1:0] RST_SLOPE  = 31'd16777216;
    localparam logic [REG_W-1:0] RST_STATIC = 31'd13421773;
    localparam logic [REG_W-1:0] RST_IMPED  = 31'd9227469;

    localparam logic [1:0] REG_SLOPE  = 2'd0;
    localparam logic [1:0] REG_STATIC = 2'd1;
    localparam logic [1:0] REG_IMPED  = 2'd2;

    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] PC_STICKV = 6'd36;
    localparam logic [PC_W-1:0] PC_HOLDV  = 6'd37;
    localparam logic [PC_W-1:0] PC_FINAL  = 6'd38;

    localparam logic [7:0] MUL_LAST  = 8'd5;
    localparam logic [7:0] DIV_LAST  = 8'd128;
    localparam logic [7:0] SQRT_LAST = 8'd64;

    typedef enum logic [2:0] {
        OP_NOP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SQRT
    } t_op;

    typedef enum logic [4:0] {
        SRC_ZERO, SRC_VIN, SRC_VIB, SRC_VB, SRC_FB, SRC_ZS, SRC_ZI, SRC_MUS,
        SRC_KP2, SRC_KP3, SRC_KP06, SRC_KP1,
        SRC_VH, SRC_B, SRC_C, SRC_D, SRC_T, SRC_U, SRC_V
    } t_src;

    typedef enum logic [2:0] {
        DST_NONE, DST_VH, DST_B, DST_C, DST_D, DST_T, DST_U, DST_V
    } t_dst;

    typedef enum logic [1:0] {
        STK_KEEP, STK_SET, STK_CLR
    } t_stk;

    typedef enum logic [2:0] {
        C_NEXT, C_JUMP, C_EQ_OR_NEG, C_HOLD, C_ROOT_GT, C_END
    } t_cond;

    typedef enum logic [1:0] {
        S_IDLE, S_ISSUE, S_WAIT, S_FINISH
    } t_state;

    typedef struct packed {
        t_op             op;
        t_src            a;
        t_src            b;
        t_dst            dst;
        t_stk            stk;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_step;

    typedef struct packed {
        logic  start;
        logic  load_in;
        logic  load_out;
        t_op   op;
        t_src  a;
        t_src  b;
        t_dst  dst;
        t_stk  stk;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic eq;
        logic dneg;
        logic t_pos;
        logic t_le_u;
        logic t_gt_vb;
        logic stick;
    } t_stat;

    function automatic t_step mk(t_op o, t_src a, t_src b, t_dst d, t_stk k, t_cond c,
                                 logic [PC_W-1:0] tg);
        t_step s;
        s.op = o;
        s.a = a;
        s.b = b;
        s.dst = d;
        s.stk = k;
        s.cond = c;
        s.target = tg;
        return s;
    endfunction

    // Sequence of the friction solve. Registers D and T are scratch.
    function automatic t_step ucode(logic [PC_W-1:0] pc);
        t_step s;
        case (pc)
            6'd0:  s = mk(OP_ADD, SRC_VIN, SRC_VIB, DST_VH, STK_KEEP, C_NEXT, '0);
            6'd1:  s = mk(OP_MUL, SRC_KP2, SRC_ZS, DST_D, STK_KEEP, C_NEXT, '0);
            6'd2:  s = mk(OP_SUB, SRC_ZERO, SRC_D, DST_B, STK_KEEP, C_NEXT, '0);
            6'd3:  s = mk(OP_MUL, SRC_KP3, SRC_FB, DST_T, STK_KEEP, C_NEXT, '0);
            6'd4:  s = mk(OP_SUB, SRC_B, SRC_T, DST_B, STK_KEEP, C_NEXT, '0);
            6'd5:  s = mk(OP_MUL, SRC_ZS, SRC_VB, DST_T, STK_KEEP, C_NEXT, '0);
            6'd6:  s = mk(OP_SUB, SRC_B, SRC_T, DST_B, STK_KEEP, C_NEXT, '0);
            6'd7:  s = mk(OP_MUL, SRC_ZS, SRC_VH, DST_T, STK_KEEP, C_NEXT, '0);
            6'd8:  s = mk(OP_SUB, SRC_B, SRC_T, DST_B, STK_KEEP, C_NEXT, '0);
            6'd9:  s = mk(OP_MUL, SRC_KP06, SRC_FB, DST_C, STK_KEEP, C_NEXT, '0);
            6'd10: s = mk(OP_MUL, SRC_ZS, SRC_VH, DST_T, STK_KEEP, C_NEXT, '0);
            6'd11: s = mk(OP_MUL, SRC_T, SRC_VB, DST_T, STK_KEEP, C_NEXT, '0);
            6'd12: s = mk(OP_ADD, SRC_C, SRC_T, DST_C, STK_KEEP, C_NEXT, '0);
            6'd13: s = mk(OP_MUL, SRC_D, SRC_VH, DST_T, STK_KEEP, C_NEXT, '0);
            6'd14: s = mk(OP_ADD, SRC_C, SRC_T, DST_C, STK_KEEP, C_NEXT, '0);
            6'd15: s = mk(OP_MUL, SRC_KP3, SRC_VB, DST_T, STK_KEEP, C_NEXT, '0);
            6'd16: s = mk(OP_MUL, SRC_T, SRC_FB, DST_T, STK_KEEP, C_NEXT, '0);
            6'd17: s = mk(OP_ADD, SRC_C, SRC_T, DST_C, STK_KEEP, C_NEXT, '0);
            6'd18: s = mk(OP_MUL, SRC_KP1, SRC_FB, DST_T, STK_KEEP, C_NEXT, '0);
            6'd19: s = mk(OP_ADD, SRC_C, SRC_T, DST_C, STK_KEEP, C_NEXT, '0);
            6'd20: s = mk(OP_MUL, SRC_ZS, SRC_C, DST_T, STK_KEEP, C_NEXT, '0);
            6'd21: s = mk(OP_ADD, SRC_T, SRC_T, DST_T, STK_KEEP, C_NEXT, '0);
            6'd22: s = mk(OP_ADD, SRC_T, SRC_T, DST_T, STK_KEEP, C_NEXT, '0);
            6'd23: s = mk(OP_MUL, SRC_B, SRC_B, DST_U, STK_KEEP, C_NEXT, '0);
            6'd24: s = mk(OP_SUB, SRC_U, SRC_T, DST_D, STK_KEEP, C_NEXT, '0);
            6'd25: s = mk(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, STK_KEEP, C_EQ_OR_NEG,
                          PC_STICKV);
            6'd26: s = mk(OP_SUB, SRC_VB, SRC_VH, DST_T, STK_KEEP, C_NEXT, '0);
            6'd27: s = mk(OP_MUL, SRC_ZS, SRC_T, DST_T, STK_KEEP, C_NEXT, '0);
            6'd28: s = mk(OP_MUL, SRC_MUS, SRC_FB, DST_U, STK_KEEP, C_NEXT, '0);
            6'd29: s = mk(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, STK_KEEP, C_HOLD, PC_HOLDV);
            6'd30: s = mk(OP_SQRT, SRC_D, SRC_ZERO, DST_T, STK_KEEP, C_NEXT, '0);
            6'd31: s = mk(OP_SUB, SRC_ZERO, SRC_B, DST_U, STK_KEEP, C_NEXT, '0);
            6'd32: s = mk(OP_SUB, SRC_U, SRC_T, DST_U, STK_KEEP, C_NEXT, '0);
            6'd33: s = mk(OP_DIV, SRC_U, SRC_ZS, DST_T, STK_KEEP, C_NEXT, '0);
            6'd34: s = mk(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, STK_KEEP, C_ROOT_GT,
                          PC_STICKV);
            6'd35: s = mk(OP_ADD, SRC_T, SRC_ZERO, DST_V, STK_CLR, C_JUMP, PC_FINAL);
            6'd36: s = mk(OP_ADD, SRC_VB, SRC_ZERO, DST_V, STK_SET, C_JUMP, PC_FINAL);
            6'd37: s = mk(OP_ADD, SRC_VB, SRC_ZERO, DST_V, STK_KEEP, C_NEXT, '0);
            6'd38: s = mk(OP_SUB, SRC_V, SRC_VH, DST_T, STK_KEEP, C_NEXT, '0);
            6'd39: s = mk(OP_MUL, SRC_ZS, SRC_T, DST_T, STK_KEEP, C_NEXT, '0);
            6'd40: s = mk(OP_DIV, SRC_T, SRC_ZI, DST_T, STK_KEEP, C_NEXT, '0);
            6'd41: s = mk(OP_ADD, SRC_VIB, SRC_T, DST_U, STK_KEEP, C_NEXT, '0);
            6'd42: s = mk(OP_ADD, SRC_VIN, SRC_T, DST_C, STK_KEEP, C_END, '0);
            default: s = mk(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, STK_KEEP, C_END, '0);
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/bsfj_in_if.sv -----
interface bsfj_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] nut_wave;
    logic signed [DATA_WIDTH-1:0] bridge_wave;
    logic signed [DATA_WIDTH-1:0] bow_velocity;
    logic        [DATA_WIDTH-2:0] bow_force;

    modport source (output valid, nut_wave, bridge_wave, bow_velocity, bow_force,
                    input ready);
    modport sink (input valid, nut_wave, bridge_wave, bow_velocity, bow_force,
                  output ready);
endinterface

// ----- hdl/bsfj_out_if.sv -----
interface bsfj_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] toward_nut;
    logic signed [DATA_WIDTH-1:0] toward_bridge;
    logic signed [DATA_WIDTH-1:0] string_velocity;
    logic                         sticking;

    modport source (output valid, toward_nut, toward_bridge, string_velocity, sticking,
                    input ready);
    modport sink (input valid, toward_nut, toward_bridge, string_velocity, sticking,
                  output ready);
endinterface

// ----- hdl/bsfj_ctrl.sv -----
module bsfj_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  bsfj_pkg::t_stat  i_stat,
    output bsfj_pkg::t_cmd   o_cmd
);

    bsfj_pkg::t_state             r_state, n_state;
    logic [bsfj_pkg::PC_W-1:0]    r_pc, n_pc;
    logic                         r_ovalid, n_ovalid;
    bsfj_pkg::t_step              w_step;
    logic                         w_taken;
    logic                         w_load_out;

    assign w_step = bsfj_pkg::ucode(r_pc);
    assign w_load_out = (r_state == bsfj_pkg::S_FINISH) && (!r_ovalid || i_out_ready);

    always_comb begin
        case (w_step.cond)
            bsfj_pkg::C_JUMP:      w_taken = 1'b1;
            bsfj_pkg::C_EQ_OR_NEG: w_taken = i_stat.eq | i_stat.dneg;
            bsfj_pkg::C_HOLD:      w_taken = i_stat.stick & i_stat.t_pos & i_stat.t_le_u;
            bsfj_pkg::C_ROOT_GT:   w_taken = i_stat.t_gt_vb;
            default:               w_taken = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_pc = r_pc;
        case (r_state)
            bsfj_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = bsfj_pkg::S_ISSUE;
                    n_pc = '0;
                end
            end
            bsfj_pkg::S_ISSUE: begin
                n_state = bsfj_pkg::S_WAIT;
            end
            bsfj_pkg::S_WAIT: begin
                if (i_stat.done) begin
                    if (w_step.cond == bsfj_pkg::C_END) begin
                        n_state = bsfj_pkg::S_FINISH;
                    end else begin
                        n_state = bsfj_pkg::S_ISSUE;
                        n_pc = w_taken ? w_step.target : r_pc + 1'b1;
                    end
                end
            end
            bsfj_pkg::S_FINISH: begin
                if (w_load_out) begin
                    n_state = bsfj_pkg::S_IDLE;
                end
            end
            default: n_state = bsfj_pkg::S_IDLE;
        endcase
        if (w_load_out) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    // Outputs.
    always_comb begin
        o_in_ready = (r_state == bsfj_pkg::S_IDLE);
        o_out_valid = r_ovalid;
        o_cmd.start = (r_state == bsfj_pkg::S_ISSUE);
        o_cmd.load_in = (r_state == bsfj_pkg::S_IDLE) && i_in_valid;
        o_cmd.load_out = w_load_out;
        o_cmd.op = w_step.op;
        o_cmd.a = w_step.a;
        o_cmd.b = w_step.b;
        o_cmd.dst = w_step.dst;
        o_cmd.stk = w_step.stk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsfj_pkg::S_IDLE;
            r_pc <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc <= n_pc;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// ----- hdl/bsfj_dp.sv -----
module bsfj_dp #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bsfj_pkg::t_cmd                      i_cmd,
    output bsfj_pkg::t_stat                     o_stat,
    input  logic signed [DATA_WIDTH-1:0]        i_nut_wave,
    input  logic signed [DATA_WIDTH-1:0]        i_bridge_wave,
    input  logic signed [DATA_WIDTH-1:0]        i_bow_velocity,
    input  logic        [DATA_WIDTH-2:0]        i_bow_force,
    input  logic [bsfj_pkg::REG_W-1:0]          i_slope,
    input  logic [bsfj_pkg::REG_W-1:0]          i_static,
    input  logic [bsfj_pkg::REG_W-1:0]          i_imped,
    output logic signed [DATA_WIDTH-1:0]        o_toward_nut,
    output logic signed [DATA_WIDTH-1:0]        o_toward_bridge,
    output logic signed [DATA_WIDTH-1:0]        o_string_velocity,
    output logic                                o_sticking
);

    localparam int W = bsfj_pkg::W;
    localparam logic [W-1:0] ONE_Q = 64'd1 << FRAC_BITS;
    localparam logic signed [W-1:0] KP2  = (ONE_Q * 64'd2 + 64'd5) / 64'd10;
    localparam logic signed [W-1:0] KP3  = (ONE_Q * 64'd3 + 64'd5) / 64'd10;
    localparam logic signed [W-1:0] KP06 = (ONE_Q * 64'd6 + 64'd50) / 64'd100;
    localparam logic signed [W-1:0] KP1  = (ONE_Q + 64'd5) / 64'd10;
    localparam logic signed [W-1:0] OMAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam logic signed [W-1:0] OMIN = -OMAX - 64'sd1;

    logic signed [W-1:0] r_vin, r_vib, r_vb, r_fb;
    logic signed [W-1:0] r_vh, r_b, r_c, r_d, r_t, r_u, r_v;
    logic                r_stick;
    logic                r_busy, r_done;
    logic [7:0]          r_cnt;
    bsfj_pkg::t_op       r_op;
    bsfj_pkg::t_dst      r_dst;
    logic [W-1:0]        r_ma, r_mb;
    logic                r_neg;
    logic [2*W-1:0]      r_sh, r_q, r_acc;
    logic [W+2:0]        r_rem;
    logic [W-1:0]        r_pp;
    logic [1:0]          r_pj;
    logic signed [DATA_WIDTH-1:0] r_o_nut, r_o_bridge, r_o_sv;
    logic                r_o_stick;

    logic signed [W-1:0] w_zs, w_zi, w_a, w_b, w_bb, w_alu, w_unit, w_wval;
    logic [W-1:0]        w_ma, w_mb, w_mag;
    logic signed [W:0]   w_sum;
    logic [7:0]          w_last;
    logic                w_wen;
    bsfj_pkg::t_dst      w_wdst;
    logic [31:0]         w_ha, w_hb;
    logic [W-1:0]        w_prod;
    logic [2*W-1:0]      w_pp_sh, w_mshift;
    logic [W+2:0]        w_srem, w_strial;
    logic [33:0]         w_drem, w_dden;

    function automatic logic signed [DATA_WIDTH-1:0] osat(logic signed [W-1:0] x);
        logic signed [W-1:0] y;
        if (x > OMAX) begin
            y = OMAX;
        end else if (x < OMIN) begin
            y = OMIN;
        end else begin
            y = x;
        end
        return y[DATA_WIDTH-1:0];
    endfunction

    // A zero slope or impedance acts as one LSB.
    assign w_zs = (i_slope == '0) ? 64'sd1 : {{(W - bsfj_pkg::REG_W){1'b0}}, i_slope};
    assign w_zi = (i_imped == '0) ? 64'sd1 : {{(W - bsfj_pkg::REG_W){1'b0}}, i_imped};

    function automatic logic signed [W-1:0] pick(bsfj_pkg::t_src s,
            logic signed [W-1:0] zs, logic signed [W-1:0] zi);
        logic signed [W-1:0] x;
        case (s)
            bsfj_pkg::SRC_VIN:  x = r_vin;
            bsfj_pkg::SRC_VIB:  x = r_vib;
            bsfj_pkg::SRC_VB:   x = r_vb;
            bsfj_pkg::SRC_FB:   x = r_fb;
            bsfj_pkg::SRC_ZS:   x = zs;
            bsfj_pkg::SRC_ZI:   x = zi;
            bsfj_pkg::SRC_MUS:  x = {{(W - bsfj_pkg::REG_W){1'b0}}, i_static};
            bsfj_pkg::SRC_KP2:  x = KP2;
            bsfj_pkg::SRC_KP3:  x = KP3;
            bsfj_pkg::SRC_KP06: x = KP06;
            bsfj_pkg::SRC_KP1:  x = KP1;
            bsfj_pkg::SRC_VH:   x = r_vh;
            bsfj_pkg::SRC_B:    x = r_b;
            bsfj_pkg::SRC_C:    x = r_c;
            bsfj_pkg::SRC_D:    x = r_d;
            bsfj_pkg::SRC_T:    x = r_t;
            bsfj_pkg::SRC_U:    x = r_u;
            bsfj_pkg::SRC_V:    x = r_v;
            default:            x = '0;
        endcase
        return x;
    endfunction

    always_comb begin
        w_a = pick(i_cmd.a, w_zs, w_zi);
        w_b = pick(i_cmd.b, w_zs, w_zi);
    end
    assign w_ma = w_a[W-1] ? W'(-w_a) : W'(w_a);
    assign w_mb = w_b[W-1] ? W'(-w_b) : W'(w_b);

    // Saturating add or subtract; the clamp is symmetric around zero.
    assign w_bb = (i_cmd.op == bsfj_pkg::OP_SUB) ? -w_b : w_b;
    assign w_sum = {w_a[W-1], w_a} + {w_bb[W-1], w_bb};
    always_comb begin
        if (w_sum > $signed({1'b0, bsfj_pkg::WMAX})) begin
            w_alu = bsfj_pkg::WMAX;
        end else if (w_sum < -$signed({1'b0, bsfj_pkg::WMAX})) begin
            w_alu = -bsfj_pkg::WMAX;
        end else begin
            w_alu = w_sum[W-1:0];
        end
    end

    // One 32x32 partial product per cycle, registered and accumulated in the following cycle.
    assign w_ha = r_cnt[1] ? r_ma[W-1:32] : r_ma[31:0];
    assign w_hb = r_cnt[0] ? r_mb[W-1:32] : r_mb[31:0];
    assign w_prod = w_ha * w_hb;
    always_comb begin
        case (r_pj)
            2'd0:    w_pp_sh = {{W{1'b0}}, r_pp};
            2'd3:    w_pp_sh = {r_pp, {W{1'b0}}};
            default: w_pp_sh = {{(W - 32){1'b0}}, r_pp, 32'b0};
        endcase
    end
    assign w_mshift = r_acc >> FRAC_BITS;

    assign w_srem = {r_rem[W:0], r_sh[2*W-1 -: 2]};
    assign w_strial = {r_q[W:0], 2'b01};
    assign w_drem = {r_rem[32:0], r_sh[2*W-1]};
    assign w_dden = {r_mb[31:0], 2'b0} >> 1;

    always_comb begin
        case (r_op)
            bsfj_pkg::OP_MUL:  w_last = bsfj_pkg::MUL_LAST;
            bsfj_pkg::OP_DIV:  w_last = bsfj_pkg::DIV_LAST;
            default:           w_last = bsfj_pkg::SQRT_LAST;
        endcase
    end

    always_comb begin
        case (r_op)
            bsfj_pkg::OP_MUL: begin
                w_mag = (|r_acc[2*W-1:W-1+FRAC_BITS]) ? W'(bsfj_pkg::WMAX)
                                                      : w_mshift[W-1:0];
            end
            bsfj_pkg::OP_DIV: begin
                w_mag = (|r_q[2*W-1:W-1]) ? W'(bsfj_pkg::WMAX) : r_q[W-1:0];
            end
            default: w_mag = r_q[W-1:0];
        endcase
        w_unit = r_neg ? -$signed(w_mag) : $signed(w_mag);
    end

    always_comb begin
        if (i_cmd.start) begin
            w_wen = (i_cmd.op == bsfj_pkg::OP_ADD) || (i_cmd.op == bsfj_pkg::OP_SUB);
            w_wdst = i_cmd.dst;
            w_wval = w_alu;
        end else begin
            w_wen = r_busy && (r_cnt == w_last);
            w_wdst = r_dst;
            w_wval = w_unit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
            r_stick <= 1'b1;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                case (i_cmd.stk)
                    bsfj_pkg::STK_SET: r_stick <= 1'b1;
                    bsfj_pkg::STK_CLR: r_stick <= 1'b0;
                    default:           r_stick <= r_stick;
                endcase
                r_cnt <= '0;
                if ((i_cmd.op == bsfj_pkg::OP_MUL) || (i_cmd.op == bsfj_pkg::OP_DIV) ||
                        (i_cmd.op == bsfj_pkg::OP_SQRT)) begin
                    r_busy <= 1'b1;
                end else begin
                    r_done <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op <= i_cmd.op;
            r_dst <= i_cmd.dst;
            r_ma <= w_ma;
            r_mb <= w_mb;
            r_neg <= (i_cmd.op == bsfj_pkg::OP_MUL) ? (w_a[W-1] ^ w_b[W-1]) :
                     (i_cmd.op == bsfj_pkg::OP_DIV) ? w_a[W-1] : 1'b0;
            r_sh <= {{W{1'b0}}, w_ma} << FRAC_BITS;
            r_rem <= '0;
            r_q <= '0;
            r_acc <= '0;
        end else if (r_busy) begin
            case (r_op)
                bsfj_pkg::OP_MUL: begin
                    if (r_cnt < 8'd4) begin
                        r_pp <= w_prod;
                        r_pj <= r_cnt[1:0];
                    end
                    if ((r_cnt != 8'd0) && (r_cnt < bsfj_pkg::MUL_LAST)) begin
                        r_acc <= r_acc + w_pp_sh;
                    end
                end
                bsfj_pkg::OP_DIV: begin
                    if (r_cnt < bsfj_pkg::DIV_LAST) begin
                        r_sh <= r_sh << 1;
                        if (w_drem >= w_dden) begin
                            r_rem <= {{(W - 31){1'b0}}, w_drem - w_dden};
                            r_q <= {r_q[2*W-2:0], 1'b1};
                        end else begin
                            r_rem <= {{(W - 31){1'b0}}, w_drem};
                            r_q <= {r_q[2*W-2:0], 1'b0};
                        end
                    end
                end
                bsfj_pkg::OP_SQRT: begin
                    if (r_cnt < bsfj_pkg::SQRT_LAST) begin
                        r_sh <= r_sh << 2;
                        if (w_srem >= w_strial) begin
                            r_rem <= w_srem - w_strial;
                            r_q <= {r_q[2*W-2:0], 1'b1};
                        end else begin
                            r_rem <= w_srem;
                            r_q <= {r_q[2*W-2:0], 1'b0};
                        end
                    end
                end
                default: r_acc <= r_acc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_vin <= {{(W - DATA_WIDTH){i_nut_wave[DATA_WIDTH-1]}}, i_nut_wave};
            r_vib <= {{(W - DATA_WIDTH){i_bridge_wave[DATA_WIDTH-1]}}, i_bridge_wave};
            r_vb <= {{(W - DATA_WIDTH){i_bow_velocity[DATA_WIDTH-1]}}, i_bow_velocity};
            r_fb <= {{(W - DATA_WIDTH + 1){1'b0}}, i_bow_force};
        end
        if (w_wen) begin
            case (w_wdst)
                bsfj_pkg::DST_VH: r_vh <= w_wval;
                bsfj_pkg::DST_B:  r_b <= w_wval;
                bsfj_pkg::DST_C:  r_c <= w_wval;
                bsfj_pkg::DST_D:  r_d <= w_wval;
                bsfj_pkg::DST_T:  r_t <= w_wval;
                bsfj_pkg::DST_U:  r_u <= w_wval;
                bsfj_pkg::DST_V:  r_v <= w_wval;
                default:          r_v <= r_v;
            endcase
        end
        if (i_cmd.load_out) begin
            r_o_nut <= osat(-r_u);
            r_o_bridge <= osat(-r_c);
            r_o_sv <= osat(r_v);
            r_o_stick <= r_stick;
        end
    end

    always_comb begin
        o_stat.done = r_done;
        o_stat.eq = (r_vh == r_vb);
        o_stat.dneg = r_d[W-1];
        o_stat.t_pos = (r_t > 64'sd0);
        o_stat.t_le_u = (r_t <= r_u);
        o_stat.t_gt_vb = (r_t > r_vb);
        o_stat.stick = r_stick;
    end

    assign o_toward_nut = r_o_nut;
    assign o_toward_bridge = r_o_bridge;
    assign o_string_velocity = r_o_sv;
    assign o_sticking = r_o_stick;

endmodule

// ----- hdl/bowed_string_friction_junction.sv -----
// A result is ready sooner when the first test settles on sticking than when the slipping
// root is solved; for that root, two divisions and one square root on the shared
// arithmetic unit set most of the time.
// One request is in flight at a time; the next request is taken once a result sits in
// the output register, which holds it until the sink takes it.
// Reset: config registers return to their defaults, the stick flag is set, no data held.
module bowed_string_friction_junction #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bsfj_in_if.sink      i_in,
    bsfj_out_if.source   o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [bsfj_pkg::REG_W-1:0] r_slope, r_static, r_imped;
    logic                       w_wr;
    bsfj_pkg::t_cmd             w_cmd;
    bsfj_pkg::t_stat            w_stat;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope <= bsfj_pkg::RST_SLOPE;
            r_static <= bsfj_pkg::RST_STATIC;
            r_imped <= bsfj_pkg::RST_IMPED;
        end else if (w_wr) begin
            case (paddr[3:2])
                bsfj_pkg::REG_SLOPE:  r_slope <= pwdata[bsfj_pkg::REG_W-1:0];
                bsfj_pkg::REG_STATIC: r_static <= pwdata[bsfj_pkg::REG_W-1:0];
                bsfj_pkg::REG_IMPED:  r_imped <= pwdata[bsfj_pkg::REG_W-1:0];
                default:              r_slope <= r_slope;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            bsfj_pkg::REG_SLOPE:  prdata = {1'b0, r_slope};
            bsfj_pkg::REG_STATIC: prdata = {1'b0, r_static};
            bsfj_pkg::REG_IMPED:  prdata = {1'b0, r_imped};
            default:              prdata = '0;
        endcase
    end

    bsfj_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bsfj_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_nut_wave        (i_in.nut_wave),
        .i_bridge_wave     (i_in.bridge_wave),
        .i_bow_velocity    (i_in.bow_velocity),
        .i_bow_force       (i_in.bow_force),
        .i_slope           (r_slope),
        .i_static          (r_static),
        .i_imped           (r_imped),
        .o_toward_nut      (o_out.toward_nut),
        .o_toward_bridge   (o_out.toward_bridge),
        .o_string_velocity (o_out.string_velocity),
        .o_sticking        (o_out.sticking)
    );

endmodule
